@@ hdl/csvp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

    // largest field the store holds unless the top level is given another depth
    localparam int FIELD_MAX_DEFAULT = 64;

    // characters with a meaning of their own
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // result user bits, from the lowest bit up
    localparam int USER_W = 3;

    // parser modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_QSEEN  = 2'd2
    } mode_t;

    // per-field control handed from the parser to the emitter
    typedef struct packed {
        logic empty;
        logic line_last;
        logic truncated;
    } emit_flags_t;

endpackage

`default_nettype wire

@@ hdl/csvp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port that holds its data while idle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/csvp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csvp_front
    import csvp_pkg::*;
#(
    parameter int FIELD_MAX = FIELD_MAX_DEFAULT,
    parameter int IDX_W     = $clog2(FIELD_MAX),
    parameter int LEN_W     = $clog2(FIELD_MAX + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input transaction
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              line_end,
    // field store write port
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [7:0]             wr_data,
    // field ready for emission
    output logic                   req_valid,
    output logic [IDX_W-1:0]       req_lo,
    output logic [LEN_W-1:0]       req_hi,
    output emit_flags_t            req_flags
);

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             any_ns_reg, any_ns_next;
    logic [IDX_W-1:0] first_idx_reg, first_idx_next;
    logic             first_q_reg, first_q_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             last_q_reg, last_q_next;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    logic             normal_path;
    logic             do_push;
    logic             emit_comma;
    logic [LEN_W-1:0] lo_c;
    logic [LEN_W-1:0] hi_c;

    assign wr_addr = len_reg[IDX_W-1:0];
    assign wr_data = in_byte;

    // mode step, field store push, trim bounds kept as bytes arrive
    always_comb begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        any_ns_next    = any_ns_reg;
        first_idx_next = first_idx_reg;
        first_q_next   = first_q_reg;
        last_idx_next  = last_idx_reg;
        last_q_next    = last_q_reg;
        normal_path    = 1'b0;
        do_push        = 1'b0;
        emit_comma     = 1'b0;
        wr_en          = 1'b0;
        req_valid      = 1'b0;
        lo_c           = '0;
        hi_c           = '0;
        req_flags      = '0;

        if (accept) begin
            case (mode_reg)
                MODE_QUOTED: begin
                    do_push = 1'b1;
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_QSEEN;
                    end
                end
                MODE_QSEEN: begin
                    // doubled quote keeps the one already stored
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_QUOTED;
                    end else begin
                        mode_next   = MODE_NORMAL;
                        normal_path = 1'b1;
                    end
                end
                default: begin
                    normal_path = 1'b1;
                end
            endcase

            if (normal_path) begin
                if (in_byte == CH_COMMA) begin
                    emit_comma = 1'b1;
                end else begin
                    do_push = 1'b1;
                    if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_QUOTED;
                    end
                end
            end

            // store the byte or note the overflow
            if (do_push) begin
                if (len_reg < LEN_W'(FIELD_MAX)) begin
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                    if (!is_space(in_byte)) begin
                        if (!any_ns_reg) begin
                            first_idx_next = len_reg[IDX_W-1:0];
                            first_q_next   = (in_byte == CH_QUOTE);
                        end
                        any_ns_next   = 1'b1;
                        last_idx_next = len_reg[IDX_W-1:0];
                        last_q_next   = (in_byte == CH_QUOTE);
                    end
                end else begin
                    ovf_next = 1'b1;
                end
            end

            // field bounds after trimming and quote stripping
            lo_c = LEN_W'(first_idx_next) + LEN_W'(first_q_next);
            hi_c = LEN_W'(last_idx_next) + LEN_W'(1);
            if (first_q_next && last_q_next && hi_c > lo_c) begin
                hi_c = hi_c - LEN_W'(1);
            end

            req_valid           = emit_comma || (line_end && len_next != '0);
            req_flags.empty     = !any_ns_next || (hi_c == lo_c);
            req_flags.line_last = line_end;
            req_flags.truncated = ovf_next;

            // a finished field or line starts over
            if (req_valid || line_end) begin
                len_next    = '0;
                ovf_next    = 1'b0;
                any_ns_next = 1'b0;
            end
            if (line_end) begin
                mode_next = MODE_NORMAL;
            end
        end
    end

    assign req_lo = lo_c[IDX_W-1:0];
    assign req_hi = hi_c;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            any_ns_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            any_ns_reg <= any_ns_next;
        end
    end

    // trim bound payload, qualified by any_ns_reg
    always_ff @(posedge aclk) begin
        first_idx_reg <= first_idx_next;
        first_q_reg   <= first_q_next;
        last_idx_reg  <= last_idx_next;
        last_q_reg    <= last_q_next;
    end

endmodule

`default_nettype wire

@@ hdl/csvp_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csvp_emit
    import csvp_pkg::*;
#(
    parameter int FIELD_MAX = FIELD_MAX_DEFAULT,
    parameter int IDX_W     = $clog2(FIELD_MAX),
    parameter int LEN_W     = $clog2(FIELD_MAX + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // field request from the parser
    input  wire logic              req_valid,
    input  wire logic [IDX_W-1:0]  req_lo,
    input  wire logic [LEN_W-1:0]  req_hi,
    input  wire emit_flags_t       req_flags,
    output logic                   busy,
    // field store read port
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  wire logic [7:0]        rd_data,
    // result channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // out_byte
    output logic                   m_tlast,   // field_last
    output logic [USER_W-1:0]      m_tuser    // byte_valid, line_last, truncated
);

    logic             busy_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [LEN_W-1:0] hi_reg;
    emit_flags_t      flags_reg;

    // read data stage, the ram output register holds the byte
    logic             q_valid_reg;
    logic             q_zero_reg;
    logic             q_flast_reg;
    logic             q_llast_reg;
    logic             q_trunc_reg;

    // output register
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic             m_bvalid_reg;
    logic             m_flast_reg;
    logic             m_llast_reg;
    logic             m_trunc_reg;

    logic             out_load;
    logic             issue;
    logic             issue_last;

    assign out_load   = q_valid_reg && (!m_valid_reg || m_tready);
    assign issue      = busy_reg && (!q_valid_reg || out_load);
    assign issue_last = flags_reg.empty || (LEN_W'(addr_reg) + LEN_W'(1) == hi_reg);

    assign busy    = busy_reg;
    assign rd_en   = issue && !flags_reg.empty;
    assign rd_addr = addr_reg;

    // read sequencer and stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (req_valid) begin
                busy_reg <= 1'b1;
            end else if (issue && issue_last) begin
                busy_reg <= 1'b0;
            end

            if (issue) begin
                q_valid_reg <= 1'b1;
            end else if (out_load) begin
                q_valid_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // field bounds, per-byte tags and result payload
    always_ff @(posedge aclk) begin
        if (req_valid) begin
            addr_reg  <= req_lo;
            hi_reg    <= req_hi;
            flags_reg <= req_flags;
        end else if (issue) begin
            addr_reg <= addr_reg + IDX_W'(1);
        end

        if (issue) begin
            q_zero_reg  <= flags_reg.empty;
            q_flast_reg <= issue_last;
            q_llast_reg <= flags_reg.line_last;
            q_trunc_reg <= flags_reg.truncated;
        end

        if (out_load) begin
            m_byte_reg   <= q_zero_reg ? 8'd0 : rd_data;
            m_bvalid_reg <= !q_zero_reg;
            m_flast_reg  <= q_flast_reg;
            m_llast_reg  <= q_llast_reg;
            m_trunc_reg  <= q_trunc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_flast_reg;
    assign m_tuser  = {m_trunc_reg, m_llast_reg, m_bvalid_reg};

endmodule

`default_nettype wire

@@ hdl/csv_line_field_parser_top.sv @@
// CSV line field parser
//
// Slave channel s_*: one byte of a CSV line per transaction, s_tlast on the
// line's last byte. Master channel m_*: the cleaned fields, one byte per
// transaction, m_tlast on the last byte of a field, m_tuser carrying
// byte_valid (low for the single transaction of an empty field), line_last
// and truncated.
// Field bytes are written to a single-port-write field store as they arrive,
// one byte per cycle while s_tready is high. A comma, or the end of a line
// with bytes stored, hands the field to the emitter, which reads the store
// one byte per cycle unless m_tready stalls it; trim and quote bounds are
// tracked while writing, so no scan is needed. m_tvalid for the first
// result byte of a field rises once its request has passed the emitter's
// busy flag, the store read register and the output register; s_tready is
// low while the emitter is reading out a field. A stalled m_tready holds the
// output register and the store read, so reading pauses and no byte is lost.
// Reset (aresetn low, synchronous) empties the field, returns to normal mode
// and drops any results not yet taken; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module csv_line_field_parser_top
    import csvp_pkg::*;
#(
    parameter int FIELD_MAX = FIELD_MAX_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input bytes
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // in_byte
    input  wire logic              s_tlast,   // line_end
    // result bytes
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // out_byte
    output logic                   m_tlast,   // field_last
    output logic [USER_W-1:0]      m_tuser    // byte_valid, line_last, truncated
);

    localparam int IDX_W = $clog2(FIELD_MAX);
    localparam int LEN_W = $clog2(FIELD_MAX + 1);

    logic             accept;
    logic             busy;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             req_valid;
    logic [IDX_W-1:0] req_lo;
    logic [LEN_W-1:0] req_hi;
    emit_flags_t      req_flags;

    // input is held off while a field is read out
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    csvp_front #(
        .FIELD_MAX (FIELD_MAX),
        .IDX_W     (IDX_W),
        .LEN_W     (LEN_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_byte   (s_tdata),
        .line_end  (s_tlast),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .req_valid (req_valid),
        .req_lo    (req_lo),
        .req_hi    (req_hi),
        .req_flags (req_flags)
    );

    // field store
    csvp_ram #(
        .WIDTH (8),
        .DEPTH (FIELD_MAX)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csvp_emit #(
        .FIELD_MAX (FIELD_MAX),
        .IDX_W     (IDX_W),
        .LEN_W     (LEN_W)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_lo    (req_lo),
        .req_hi    (req_hi),
        .req_flags (req_flags),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import csvp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM_BYTES = 320;
    localparam int DRAIN_CYCLES = 30;

    // one byte of a cleaned field as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       field_last;
        logic       line_last;
        logic       truncated;
    } field_byte_t;

    // kinds of field the random lines are built from
    typedef enum int {
        FK_PLAIN,
        FK_QUOTED,
        FK_EMPTY,
        FK_SPACED,
        FK_NOISE,
        FK_LONG
    } field_kind_t;

    // tracks the parser state and holds the field bytes still to come out
    class csv_field_scoreboard;
        logic [7:0]  store [FIELD_MAX_DEFAULT];
        int          fill;
        mode_t       mode;
        bit          overflow;
        field_byte_t expected_bytes [$];
        int          errors;

        function new();
            fill = 0;
            mode = MODE_NORMAL;
            overflow = 0;
            errors = 0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function void store_byte(logic [7:0] b);
            if (fill < FIELD_MAX_DEFAULT) begin
                store[fill] = b;
                fill++;
            end else begin
                overflow = 1;
            end
        endfunction

        // trim blanks, then a leading quote and one trailing quote
        function void close_field(bit line_last);
            int lo;
            int hi;
            field_byte_t r;
            lo = 0;
            hi = fill;
            while (lo < hi && is_blank(store[lo])) lo++;
            while (hi > lo && is_blank(store[hi - 1])) hi--;
            if (hi > lo && store[lo] == CH_QUOTE) begin
                lo++;
                if (hi > lo && store[hi - 1] == CH_QUOTE) hi--;
            end
            if (hi == lo) begin
                r = '{data: 8'h00, byte_valid: 1'b0, field_last: 1'b1,
                      line_last: line_last, truncated: overflow};
                expected_bytes.push_back(r);
            end else begin
                for (int i = lo; i < hi; i++) begin
                    r = '{data: store[i], byte_valid: 1'b1, field_last: (i + 1 == hi),
                          line_last: line_last, truncated: overflow};
                    expected_bytes.push_back(r);
                end
            end
            fill = 0;
            overflow = 0;
        endfunction

        // one accepted input transaction
        function void consume_line_byte(logic [7:0] b, logic line_end);
            bit as_normal;
            as_normal = 0;
            case (mode)
                MODE_QUOTED: begin
                    store_byte(b);
                    if (b == CH_QUOTE) mode = MODE_QSEEN;
                end
                MODE_QSEEN: begin
                    if (b == CH_QUOTE) begin
                        mode = MODE_QUOTED;
                    end else begin
                        mode = MODE_NORMAL;
                        as_normal = 1;
                    end
                end
                default: as_normal = 1;
            endcase
            if (as_normal) begin
                if (b == CH_COMMA) begin
                    close_field(line_end);
                end else begin
                    if (b == CH_QUOTE) mode = MODE_QUOTED;
                    store_byte(b);
                end
            end
            if (line_end) begin
                if (fill > 0) close_field(1'b1);
                fill = 0;
                overflow = 0;
                mode = MODE_NORMAL;
            end
        endfunction

        function void report(string what, field_byte_t exp_b, field_byte_t act_b);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch (%s): expected data=%h valid=%b flast=%b llast=%b trunc=%b, got data=%h valid=%b flast=%b llast=%b trunc=%b",
                         $realtime, what, exp_b.data, exp_b.byte_valid, exp_b.field_last,
                         exp_b.line_last, exp_b.truncated, act_b.data, act_b.byte_valid,
                         act_b.field_last, act_b.line_last, act_b.truncated);
        endfunction

        // one accepted output transaction
        function void check_field_byte(logic [7:0] data, logic last, logic [USER_W-1:0] user);
            field_byte_t act_b;
            field_byte_t exp_b;
            act_b = '{data: data, byte_valid: user[0], field_last: last,
                      line_last: user[1], truncated: user[2]};
            if (expected_bytes.size() == 0) begin
                report("unexpected", '0, act_b);
                return;
            end
            exp_b = expected_bytes.pop_front();
            // data is meaningless on the result of an empty field
            if ((exp_b.byte_valid && act_b.data !== exp_b.data) ||
                act_b.byte_valid !== exp_b.byte_valid ||
                act_b.field_last !== exp_b.field_last ||
                act_b.line_last !== exp_b.line_last ||
                act_b.truncated !== exp_b.truncated)
                report("field", exp_b, act_b);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic [USER_W-1:0] m_tuser;

    csv_field_scoreboard sb;
    logic [7:0] line_bytes [$];
    int   bytes_sent;
    bit   send_burst;
    bit   recv_burst;
    int   idle_cycles;

    csv_line_field_parser_top #(
        .FIELD_MAX(FIELD_MAX_DEFAULT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // printable byte that is neither a comma nor a quote
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126));
        while (c == CH_COMMA || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(9 + k);
    endfunction

    // one input transaction, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic line_end);
        int gap;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= line_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.consume_line_byte(b, line_end);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    // append one random field to the line under construction
    task automatic add_field(input field_kind_t kind);
        int n;
        case (kind)
            FK_PLAIN: begin
                n = $urandom_range(1, 6);
                repeat (n) line_bytes.push_back(text_byte());
            end
            FK_QUOTED: begin
                if ($urandom_range(0, 3) == 0) line_bytes.push_back(blank_byte());
                line_bytes.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            line_bytes.push_back(CH_QUOTE);
                            line_bytes.push_back(CH_QUOTE);
                        end
                        2: line_bytes.push_back(CH_COMMA);
                        3: line_bytes.push_back(blank_byte());
                        default: line_bytes.push_back(text_byte());
                    endcase
                end
                line_bytes.push_back(CH_QUOTE);
                // text after the closing quote drops back to normal mode
                if ($urandom_range(0, 5) == 0) line_bytes.push_back(text_byte());
                if ($urandom_range(0, 3) == 0) line_bytes.push_back(blank_byte());
            end
            FK_EMPTY: begin
            end
            FK_SPACED: begin
                n = $urandom_range(0, 3);
                repeat (n) line_bytes.push_back(blank_byte());
                n = $urandom_range(0, 3);
                repeat (n) line_bytes.push_back(text_byte());
                n = $urandom_range(0, 3);
                repeat (n) line_bytes.push_back(blank_byte());
            end
            FK_NOISE: begin
                n = $urandom_range(1, 8);
                repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                n = $urandom_range(FIELD_MAX_DEFAULT - 2, FIELD_MAX_DEFAULT + 8);
                repeat (n) line_bytes.push_back(text_byte());
            end
        endcase
    endtask

    // result side: random stall ahead of each transaction
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_field_byte(m_tdata, m_tlast, m_tuser);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        field_kind_t kind;
        int  n_fields;
        bit  long_done;
        sb = new();
        bytes_sent = 0;
        send_burst = 0;
        recv_burst = 0;
        idle_cycles = 0;
        long_done = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty field between two plain ones
        line_bytes = '{"a", CH_COMMA, CH_COMMA, "b"};
        send_line();
        // doubled quote inside quotes, extreme byte values
        line_bytes = '{CH_QUOTE, "x", CH_QUOTE, CH_QUOTE, "y", CH_QUOTE, CH_COMMA,
                       8'h00, 8'hFF};
        send_line();
        // text after a closing quote, line ending on a comma
        line_bytes = '{CH_QUOTE, "a", CH_QUOTE, "b", CH_COMMA};
        send_line();
        // blanks trimmed at both ends
        line_bytes = '{8'h09, 8'h20, "z", 8'h0D, 8'h0C, 8'h0A};
        send_line();
        // bytes just outside the blank range are kept
        line_bytes = '{8'h08, 8'h20, 8'h0E};
        send_line();

        // random lines
        while (bytes_sent < N_RANDOM_BYTES + 30) begin
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++) begin
                if (f > 0) line_bytes.push_back(CH_COMMA);
                case ($urandom_range(0, 29))
                    0, 1, 2, 3, 4, 5, 6, 7:      kind = FK_PLAIN;
                    8, 9, 10, 11, 12, 13, 14, 15: kind = FK_QUOTED;
                    16, 17, 18:                  kind = FK_EMPTY;
                    19, 20, 21, 22, 23:          kind = FK_SPACED;
                    24, 25, 26, 27, 28:          kind = FK_NOISE;
                    default:                     kind = FK_LONG;
                endcase
                if (!long_done && bytes_sent > 150) kind = FK_LONG;
                if (kind == FK_LONG) long_done = 1;
                add_field(kind);
            end
            if ($urandom_range(0, 5) == 0 || line_bytes.size() == 0)
                line_bytes.push_back(CH_COMMA);
            send_line();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // wait for the last field to drain, then watch for stray bytes
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
